/* hdl/sawbc_pkg.sv */
// ----------------------------------------------------------------------------
// sawbc_pkg: shared definitions of the write-back cache directory
// Field widths, configuration register indexes and layout, transfer action
// codes and the default geometry limits.
// ----------------------------------------------------------------------------
package sawbc_pkg;

  // Default geometry limits of the directory storage.
  localparam int MAX_SETS_DEF = 64;
  localparam int MAX_WAYS_DEF = 8;

  // Addresses are formed in this many bits and wrap.
  localparam int ADDR_BITS = 16;

  // Widths of the transfer fields.
  localparam int ADDR_W  = 16;
  localparam int COUNT_W = 9;

  // Mask of the address bits that exist.
  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((33'd1 << ADDR_BITS) - 33'd1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WORDS_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETS_LOG2        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE      = 2'd2;

  // Configuration register contents.
  typedef struct packed {
    logic [3:0] block_words_log2;
    logic [2:0] sets_log2;
    logic [3:0] ways_in_use;
  } cfg_t;

  // Transfer actions.
  typedef enum logic [2:0] {
    ACT_READ  = 3'd0,
    ACT_WRITE = 3'd1,
    ACT_FILL  = 3'd2,
    ACT_WBACK = 3'd3,
    ACT_DROP  = 3'd4
  } action_t;

endpackage

/* hdl/set_assoc_writeback_cache_lru.sv */
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_lru: directory and controller of a write-back
// cache with true LRU replacement
// Holds the configuration registers, the tag memory and the per-set mark
// memory, and the lookup sequencer that emits each access's transfer trace.
// ----------------------------------------------------------------------------
// After reset the block sweeps the mark memory, one set a cycle, over all
// MAX_SETS rows (64 by default) before it takes its first access;
// configuration writes are taken at any time. An access is then taken in,
// its ways are scanned up to the one that hits or receives the fill (all
// ways in use when the set is full), and its records are emitted one at a
// time (one on a hit, two on a fill into a free way, three with an
// eviction), each held back while the output is stalled. The scan uses the
// single tag comparator fed from the one read port of the tag memory, one
// way per cycle.
module set_assoc_writeback_cache_lru #(
  parameter int MAX_SETS = sawbc_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS = sawbc_pkg::MAX_WAYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sawbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sawbc_pkg::CFG_DATA_W-1:0] cfg_data,
  // Accesses
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [sawbc_pkg::ADDR_W-1:0]  address,
  // Transfer records
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    action,
  output logic [sawbc_pkg::ADDR_W-1:0]  start_address,
  output logic [sawbc_pkg::COUNT_W-1:0] word_count,
  output logic                          last
);

  import sawbc_pkg::*;

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int ENT_W  = (MAX_SETS * MAX_WAYS > 1) ? $clog2(MAX_SETS * MAX_WAYS) : 1;
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ROW_W  = 2 * MAX_WAYS + MAX_WAYS * RANK_W;

  cfg_t cfg;

  logic             tag_rd_en;
  logic [ENT_W-1:0] tag_rd_addr;
  logic [15:0]      tag_rd_data;
  logic             tag_wr_en;
  logic [ENT_W-1:0] tag_wr_addr;
  logic [15:0]      tag_wr_data;
  logic             meta_rd_en;
  logic [SET_W-1:0] meta_rd_addr;
  logic [ROW_W-1:0] meta_rd_data;
  logic             meta_wr_en;
  logic [SET_W-1:0] meta_wr_addr;
  logic [ROW_W-1:0] meta_wr_data;

  // Configuration registers; a transfer to an unknown index is ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_words_log2 <= 4'd2;
      cfg.sets_log2        <= 3'd0;
      cfg.ways_in_use      <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLOCK_WORDS_LOG2: cfg.block_words_log2 <= cfg_data;
        CFG_SETS_LOG2:        cfg.sets_log2        <= cfg_data[2:0];
        CFG_WAYS_IN_USE:      cfg.ways_in_use      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Tag of every way of every set.
  sawbc_ram #(
    .DEPTH(MAX_SETS * MAX_WAYS),
    .WIDTH(16)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_wr_en),
    .wr_addr (tag_wr_addr),
    .wr_data (tag_wr_data),
    .rd_en   (tag_rd_en),
    .rd_addr (tag_rd_addr),
    .rd_data (tag_rd_data)
  );

  // Valid, dirty and rank marks, one row per set.
  sawbc_ram #(
    .DEPTH(MAX_SETS),
    .WIDTH(ROW_W)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_wr_en),
    .wr_addr (meta_wr_addr),
    .wr_data (meta_wr_data),
    .rd_en   (meta_rd_en),
    .rd_addr (meta_rd_addr),
    .rd_data (meta_rd_data)
  );

  // Lookup sequencer.
  sawbc_ctrl #(
    .MAX_SETS(MAX_SETS),
    .MAX_WAYS(MAX_WAYS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .address       (address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .start_address (start_address),
    .word_count    (word_count),
    .last          (last),
    .tag_rd_en     (tag_rd_en),
    .tag_rd_addr   (tag_rd_addr),
    .tag_rd_data   (tag_rd_data),
    .tag_wr_en     (tag_wr_en),
    .tag_wr_addr   (tag_wr_addr),
    .tag_wr_data   (tag_wr_data),
    .meta_rd_en    (meta_rd_en),
    .meta_rd_addr  (meta_rd_addr),
    .meta_rd_data  (meta_rd_data),
    .meta_wr_en    (meta_wr_en),
    .meta_wr_addr  (meta_wr_addr),
    .meta_wr_data  (meta_wr_data)
  );

endmodule

/* hdl/sawbc_ram.sv */
// ----------------------------------------------------------------------------
// sawbc_ram: simple dual-port memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sawbc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds between reads.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/sawbc_ctrl.sv */
// ----------------------------------------------------------------------------
// sawbc_ctrl: lookup sequencer of the cache directory
// Scans the ways of a set one per cycle through a single tag comparator,
// picks the LRU victim, emits the transfer records and writes back the
// updated valid, dirty and rank marks of the set.
// ----------------------------------------------------------------------------
module sawbc_ctrl #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8,
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  localparam int ENT_W  = (MAX_SETS * MAX_WAYS > 1) ? $clog2(MAX_SETS * MAX_WAYS) : 1,
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int ROW_W  = 2 * MAX_WAYS + MAX_WAYS * RANK_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sawbc_pkg::cfg_t           cfg,
  // Access channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      cmd,
  input  logic [sawbc_pkg::ADDR_W-1:0] address,
  // Transfer record channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                action,
  output logic [sawbc_pkg::ADDR_W-1:0] start_address,
  output logic [sawbc_pkg::COUNT_W-1:0] word_count,
  output logic                      last,
  // Tag memory
  output logic                      tag_rd_en,
  output logic [ENT_W-1:0]          tag_rd_addr,
  input  logic [15:0]               tag_rd_data,
  output logic                      tag_wr_en,
  output logic [ENT_W-1:0]          tag_wr_addr,
  output logic [15:0]               tag_wr_data,
  // Mark memory, one row per set
  output logic                      meta_rd_en,
  output logic [SET_W-1:0]          meta_rd_addr,
  input  logic [ROW_W-1:0]          meta_rd_data,
  output logic                      meta_wr_en,
  output logic [SET_W-1:0]          meta_wr_addr,
  output logic [ROW_W-1:0]          meta_wr_data
);

  import sawbc_pkg::*;

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int SMAX   = $clog2(MAX_SETS + 1) - 1;
  localparam logic [SET_W-1:0] LAST_ROW = SET_W'(MAX_SETS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_EVICT, S_FILL, S_WORD
  } state_t;

  typedef enum logic [1:0] {
    K_HIT, K_COLD, K_FULL
  } kind_t;

  state_t state;
  kind_t  kind;

  logic [SET_W-1:0]  clr_row;
  logic [WAY_W-1:0]  idx;
  logic [WAY_W-1:0]  way;
  logic              write_q;
  logic [ADDR_W-1:0] addr_q;
  logic [SET_W-1:0]  set_q;
  logic [15:0]       acc_tag;
  logic [3:0]        b_q;
  logic [2:0]        s_q;
  logic [WCNT_W-1:0] w_q;

  // Decoded view of the incoming access under the current configuration.
  logic [3:0]        b_in;
  logic [2:0]        s_in;
  logic [WCNT_W-1:0] w_in;
  logic [ADDR_W-1:0] addr_in;
  logic [ADDR_W-1:0] set_mask_in;
  logic [SET_W-1:0]  set_in;
  logic [15:0]       tag_in;

  // Scan and update signals.
  logic [MAX_WAYS-1:0]        row_valid;
  logic [MAX_WAYS-1:0]        row_dirty;
  logic [MAX_WAYS*RANK_W-1:0] row_rank;
  logic [MAX_WAYS-1:0]        in_use;
  logic                       cur_valid;
  logic                       cur_hit;
  logic                       last_way;
  logic                       to_evict;
  logic [WAY_W-1:0]           victim;
  logic                       slot_free;
  logic [MAX_WAYS-1:0]        new_valid;
  logic [MAX_WAYS-1:0]        new_dirty;
  logic [MAX_WAYS*RANK_W-1:0] new_rank;
  logic [WCNT_W-1:0]          fill_count;
  logic [RANK_W-1:0]          old_rank;
  logic [31:0]                victim_wide;
  logic [ADDR_W-1:0]          victim_addr;
  logic [ADDR_W-1:0]          block_lo_mask;
  logic [COUNT_W-1:0]         block_words;

  function automatic logic [ENT_W-1:0] entry(input logic [SET_W-1:0] s,
                                             input logic [WAY_W-1:0] w);
    return ENT_W'(ENT_W'(s) * ENT_W'(MAX_WAYS) + ENT_W'(w));
  endfunction

  // Split the incoming address by the clamped configuration.
  always_comb begin
    b_in = (cfg.block_words_log2 > 4'd8) ? 4'd8 : cfg.block_words_log2;
    s_in = (32'(cfg.sets_log2) > SMAX) ? 3'(SMAX) : cfg.sets_log2;
    if (cfg.ways_in_use == 4'd0) begin
      w_in = WCNT_W'(1);
    end else if (32'(cfg.ways_in_use) > MAX_WAYS) begin
      w_in = WCNT_W'(MAX_WAYS);
    end else begin
      w_in = WCNT_W'(cfg.ways_in_use);
    end
    addr_in     = address & ADDR_MASK;
    set_mask_in = ADDR_W'((17'd1 << s_in) - 17'd1);
    set_in      = SET_W'((addr_in >> b_in) & set_mask_in);
    tag_in      = addr_in >> (5'(b_in) + 5'(s_in));
  end

  // Way scan: one tag compare per cycle, LRU victim over the row.
  always_comb begin
    row_valid = meta_rd_data[MAX_WAYS-1:0];
    row_dirty = meta_rd_data[2*MAX_WAYS-1:MAX_WAYS];
    row_rank  = meta_rd_data[ROW_W-1:2*MAX_WAYS];
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = (32'(i) < 32'(w_q));
    end
    cur_valid = row_valid[idx];
    cur_hit   = cur_valid && (tag_rd_data == acc_tag);
    last_way  = (WCNT_W'(idx) + WCNT_W'(1)) == w_q;
    to_evict  = cur_valid && !cur_hit && last_way;
    victim    = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (in_use[i] && row_valid[i] && (row_rank[i*RANK_W +: RANK_W] == '0)) begin
        victim = WAY_W'(i);
      end
    end
  end

  // New marks of the set after the access.
  always_comb begin
    new_valid      = row_valid;
    new_valid[way] = 1'b1;
    fill_count     = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      fill_count = fill_count + WCNT_W'(new_valid[i] && in_use[i]);
    end
    old_rank = row_rank[way*RANK_W +: RANK_W];
    new_rank = row_rank;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if ((kind != K_COLD) && (WAY_W'(i) != way) && row_valid[i] && in_use[i] &&
          (row_rank[i*RANK_W +: RANK_W] > old_rank)) begin
        new_rank[i*RANK_W +: RANK_W] = row_rank[i*RANK_W +: RANK_W] - RANK_W'(1);
      end
    end
    new_rank[way*RANK_W +: RANK_W] = RANK_W'(fill_count - WCNT_W'(1));
    new_dirty      = row_dirty;
    new_dirty[way] = (kind == K_HIT) ? (row_dirty[way] | write_q) : write_q;
  end

  // Transfer addresses and sizes.
  always_comb begin
    victim_wide   = ((32'(tag_rd_data) << s_q) | 32'(set_q)) << b_q;
    victim_addr   = victim_wide[ADDR_W-1:0] & ADDR_MASK;
    block_lo_mask = ADDR_W'((17'd1 << b_q) - 17'd1);
    block_words   = COUNT_W'(10'd1 << b_q);
  end

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // Memory port control.
  always_comb begin
    meta_rd_en   = (state == S_IDLE) && in_valid;
    meta_rd_addr = set_in;
    tag_rd_en    = ((state == S_IDLE) && in_valid) ||
                   ((state == S_SCAN) && cur_valid && !cur_hit);
    if (state == S_IDLE) begin
      tag_rd_addr = entry(set_in, '0);
    end else if (to_evict) begin
      tag_rd_addr = entry(set_q, victim);
    end else begin
      tag_rd_addr = entry(set_q, idx + WAY_W'(1));
    end
    tag_wr_en    = (state == S_FILL) && slot_free;
    tag_wr_addr  = entry(set_q, way);
    tag_wr_data  = acc_tag;
    meta_wr_en   = (state == S_CLEAR) || ((state == S_WORD) && slot_free);
    meta_wr_addr = (state == S_CLEAR) ? clr_row : set_q;
    meta_wr_data = (state == S_CLEAR) ? '0 : {new_rank, new_dirty, new_valid};
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_row   <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_row == LAST_ROW) begin
            state <= S_IDLE;
          end else begin
            clr_row <= clr_row + SET_W'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            write_q <= cmd;
            addr_q  <= addr_in;
            set_q   <= set_in;
            acc_tag <= tag_in;
            b_q     <= b_in;
            s_q     <= s_in;
            w_q     <= w_in;
            idx     <= '0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cur_hit) begin
            way   <= idx;
            kind  <= K_HIT;
            state <= S_WORD;
          end else if (!cur_valid) begin
            way   <= idx;
            kind  <= K_COLD;
            state <= S_FILL;
          end else if (last_way) begin
            way   <= victim;
            kind  <= K_FULL;
            state <= S_EVICT;
          end else begin
            idx <= idx + WAY_W'(1);
          end
        end
        S_EVICT: begin
          if (slot_free) begin
            out_valid     <= 1'b1;
            action        <= row_dirty[way] ? ACT_WBACK : ACT_DROP;
            start_address <= victim_addr;
            word_count    <= block_words;
            last          <= 1'b0;
            state         <= S_FILL;
          end
        end
        S_FILL: begin
          if (slot_free) begin
            out_valid     <= 1'b1;
            action        <= ACT_FILL;
            start_address <= addr_q & ~block_lo_mask;
            word_count    <= block_words;
            last          <= 1'b0;
            state         <= S_WORD;
          end
        end
        S_WORD: begin
          if (slot_free) begin
            out_valid     <= 1'b1;
            action        <= write_q ? ACT_WRITE : ACT_READ;
            start_address <= addr_q;
            word_count    <= COUNT_W'(1);
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An eviction only follows a scan that found the set full.
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVICT) |-> (kind == K_FULL))
    else $error("eviction without a full set");

  // A fill never follows a hit.
  a_fill_miss: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (kind != K_HIT))
    else $error("block fill on a hit");

  // The scan stays inside the ways in use.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (WCNT_W'(idx) < w_q))
    else $error("way scan beyond the ways in use");

  // The word transfer closes the access and is flagged last.
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    ((state == S_WORD) && slot_free) |=> ((state == S_IDLE) && out_valid && last))
    else $error("access did not close with a last record");

endmodule
